/* sv/rups_pkg.sv */
// Shared types and constants of the resource unit profile scheduler.
`default_nettype none
package rups_pkg;
   localparam int NUM_RES   = 4;
   localparam int MAX_CAP   = 16;
   localparam int TIME_BITS = 16;
   localparam int NUM_CFG   = 4;
   localparam int CAP_W     = 5;
   localparam int RES_W     = 2;
   localparam int K_W       = $clog2(MAX_CAP);
   localparam int RES_IDX_W = $clog2(NUM_RES);
   localparam int ADDR_W    = RES_IDX_W + K_W;
   localparam int ROW_DEPTH = NUM_RES * MAX_CAP;
   localparam int AREA_W    = TIME_BITS + 8;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [0:0] {
      MODE_QUERY = 1'b0,
      MODE_ADD   = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QWAIT,
      ST_APREV,
      ST_ASUB,
      ST_AFILL,
      ST_SRD,
      ST_SEX
   } state_type;
endpackage
`default_nettype wire

/* sv/rups_ram.sv */
// Single-port-write, registered-read synchronous RAM.
`default_nettype none
module rups_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

/* sv/resource_unit_profile_scheduler.sv */
// Top level of the resource unit profile scheduler.
//  channel | ports                                   | content
//  req     | req_tvalid/tready/tdata/tuser/tlast     | query or add request
//  rsp     | rsp_tvalid/tready/tdata                 | earliest start
//  csr     | csr_valid/ready/index/data              | capacity registers
// A query request passes through ST_QWAIT; its result waits in an output register.
// An add request runs its setup in ST_APREV and, if needed, ST_ASUB, raises the top
// q entries in ST_AFILL, then scans row entries through ST_SRD and ST_SEX.
// The row store is one RAM with separate write and read ports; its reset state comes from 64 valid bits.
// Reset is synchronous; a stalled result holds the next query at its end.
`default_nettype none
module resource_unit_profile_scheduler
   import rups_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // resource_index, requirement, start_time, stop_time, zero pad
   input  wire logic [39:0]          req_tdata,
   // mode
   input  wire logic                 req_tuser,
   input  wire logic                 req_tlast,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // earliest_start
   output logic [15:0]               rsp_tdata,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CAP_W-1:0]     csr_data
);
   state_type state_ff, state_in;

   logic [CAP_W-1:0]     cap_ff [NUM_CFG];
   logic [ROW_DEPTH-1:0] vld_ff;
   logic                 vld_rd_ff;

   logic [RES_W-1:0]     r_ff, r_in;
   logic [CAP_W-1:0]     q_ff, q_in, capv_ff, capv_in;
   logic [TIME_BITS-1:0] start_ff, start_in, stop_ff, stop_in, nst_ff, nst_in;
   logic [TIME_BITS-1:0] max_ff, max_in;
   logic                 last_ff, last_in, qv_ff, qv_in;
   logic [CAP_W-1:0]     k_ff, k_in, c_ff, c_in;
   logic signed [AREA_W-1:0] area_ff, area_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_data_ff, rsp_data_in;

   logic                 row_we, row_re, dsp_we, dsp_re;
   logic [ADDR_W-1:0]    row_wa, row_ra;
   logic [TIME_BITS-1:0] row_wd, row_rd, row_q, dsp_wd, dsp_rd;
   logic [K_W-1:0]       dsp_wa, dsp_ra;

   // decoded request
   logic [RES_W-1:0]     d_r;
   logic [CAP_W-1:0]     d_q, d_cap, d_raw;
   logic [TIME_BITS-1:0] d_start, d_stop;
   logic                 d_valid, accept;

   assign d_r     = req_tdata[1:0];
   assign d_q     = req_tdata[6:2];
   assign d_start = req_tdata[22:7];
   assign d_stop  = req_tdata[38:23];
   assign d_raw   = cap_ff[d_r];
   assign d_cap   = (d_raw > CAP_W'(MAX_CAP)) ? CAP_W'(MAX_CAP) : d_raw;
   assign d_valid = ({1'b0, d_r} < (RES_W + 1)'(NUM_RES)) && (d_q != '0) && (d_q <= d_cap);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign row_q = vld_rd_ff ? row_rd : '0;

   logic [CAP_W-1:0]     base;
   logic [TIME_BITS-1:0] prev, nst_new, lo, qval;
   logic signed [AREA_W-1:0] diff, rem;
   logic                 out_free;

   assign base     = capv_ff - q_ff;
   assign prev     = (q_ff < capv_ff) ? row_q : stop_ff;
   assign nst_new  = (c_ff >= q_ff) ? dsp_rd : nst_ff;
   assign lo       = (row_q > start_ff) ? row_q : start_ff;
   assign diff     = $signed(AREA_W'(nst_new)) - $signed(AREA_W'(lo));
   assign rem      = area_ff - diff;
   assign qval     = (qv_ff && row_q > max_ff) ? row_q : max_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == MODE_QUERY) begin
                  state_in = ST_QWAIT;
               end else if (d_valid && d_stop > d_start) begin
                  state_in = ST_APREV;
               end
            end
         end
         ST_QWAIT: begin
            if (!last_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_APREV: state_in = (start_ff < prev) ? ST_ASUB : ST_SRD;
         ST_ASUB:  state_in = ST_AFILL;
         ST_AFILL: begin
            if (k_ff == capv_ff - 1'b1) begin
               state_in = ST_SRD;
            end
         end
         ST_SRD: begin
            if (area_ff <= 0 || k_ff == capv_ff) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SEX;
            end
         end
         ST_SEX: begin
            if (row_q < nst_ff && rem <= 0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SRD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      r_in = r_ff; q_in = q_ff; capv_in = capv_ff;
      start_in = start_ff; stop_in = stop_ff; nst_in = nst_ff;
      max_in = max_ff; last_in = last_ff; qv_in = qv_ff;
      k_in = k_ff; c_in = c_ff; area_in = area_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      row_we = 1'b0; row_wa = '0; row_wd = '0;
      row_re = 1'b0; row_ra = '0;
      dsp_we = 1'b0; dsp_wa = '0; dsp_wd = '0;
      dsp_re = 1'b0; dsp_ra = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               r_in = d_r; q_in = d_q; capv_in = d_cap;
               start_in = d_start; stop_in = d_stop;
               last_in = req_tlast; qv_in = d_valid;
               row_re = 1'b1;
               if (req_tuser == MODE_QUERY) begin
                  row_ra = {d_r, K_W'(d_cap - d_q)};
               end else begin
                  row_ra = {d_r, K_W'(d_cap - d_q - 1'b1)};
               end
            end
         end
         ST_QWAIT: begin
            if (!last_ff) begin
               max_in = qval;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = 16'(qval);
               max_in       = '0;
            end
         end
         ST_APREV: begin
            nst_in  = (stop_ff < prev) ? stop_ff : prev;
            area_in = AREA_W'(q_ff) * AREA_W'(stop_ff - start_ff);
            if (!(start_ff < prev)) begin
               k_in = '0; c_in = '0; nst_in = stop_ff;
            end
         end
         ST_ASUB: begin
            area_in = area_ff - AREA_W'(q_ff) * AREA_W'(nst_ff - start_ff);
            k_in    = base;
         end
         ST_AFILL: begin
            row_we = 1'b1;
            row_wa = {r_ff, K_W'(k_ff)};
            row_wd = nst_ff;
            k_in   = k_ff + 1'b1;
            if (k_ff == capv_ff - 1'b1) begin
               k_in = '0; c_in = '0; nst_in = stop_ff;
            end
         end
         ST_SRD: begin
            row_re = 1'b1;
            row_ra = {r_ff, K_W'(k_ff)};
            dsp_re = 1'b1;
            dsp_ra = K_W'(c_ff - q_ff);
         end
         ST_SEX: begin
            k_in = k_ff + 1'b1;
            if (row_q < nst_ff) begin
               row_we = 1'b1;
               row_wa = {r_ff, K_W'(k_ff)};
               if (rem > 0) begin
                  area_in = rem;
                  dsp_we  = 1'b1;
                  dsp_wa  = K_W'(c_ff);
                  dsp_wd  = row_q;
                  c_in    = c_ff + 1'b1;
                  row_wd  = nst_new;
                  nst_in  = nst_new;
               end else begin
                  row_wd = TIME_BITS'(AREA_W'(lo) + area_ff);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CFG; i++) begin
            cap_ff[i] <= CAP_W'(16);
         end
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         if (row_we) begin
            vld_ff[row_wa] <= 1'b1;
         end
         if (csr_valid && csr_index < CSR_IDX_W'(NUM_CFG)) begin
            cap_ff[csr_index[1:0]] <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in; q_ff <= q_in; capv_ff <= capv_in;
      start_ff <= start_in; stop_ff <= stop_in; nst_ff <= nst_in;
      last_ff <= last_in; qv_ff <= qv_in;
      k_ff <= k_in; c_ff <= c_in; area_ff <= area_in;
      rsp_data_ff <= rsp_data_in;
      if (row_re) begin
         vld_rd_ff <= vld_ff[row_ra];
      end
   end

   rups_ram #(.DEPTH(ROW_DEPTH), .WIDTH(TIME_BITS)) u_row (
      .clock(clock), .wr_en(row_we), .wr_addr(row_wa), .wr_data(row_wd),
      .rd_en(row_re), .rd_addr(row_ra), .rd_data(row_rd)
   );

   rups_ram #(.DEPTH(MAX_CAP), .WIDTH(TIME_BITS)) u_dsp (
      .clock(clock), .wr_en(dsp_we), .wr_addr(dsp_wa), .wr_data(dsp_wd),
      .rd_en(dsp_re), .rd_addr(dsp_ra), .rd_data(dsp_rd)
   );

   a_c_le_k: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEX) |-> (c_ff <= k_ff))
      else $error("displaced count ahead of scan index");
   a_wr_in_row: assert property (@(posedge clock) disable iff (reset)
      row_we |-> (k_ff < capv_ff))
      else $error("row write beyond capacity");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_QWAIT && last_ff))
      else $error("result without a closing query");
endmodule
`default_nettype wire

/* tb/resource_unit_profile_checker.sv */
// Checker: predicts earliest starts from observed requests and compares results.
`default_nettype none
module resource_unit_profile_checker
   import rups_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [39:0]          req_tdata,
   input  wire logic                 req_tuser,
   input  wire logic                 req_tlast,
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [15:0]          rsp_tdata,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CAP_W-1:0]     csr_data,
   output int                        fail_count,
   output int                        pending_starts
);
   localparam longint TIME_MASK = (64'd1 << TIME_BITS) - 1;

   logic [CAP_W-1:0]     cap_setting [NUM_CFG];
   logic [TIME_BITS-1:0] free_time   [ROW_DEPTH];
   longint               swap_time   [MAX_CAP];
   logic [TIME_BITS-1:0] running_max;
   logic [15:0]          expected_starts [$];

   initial begin
      fail_count     = 0;
      pending_starts = 0;
   end

   task automatic report(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic int usable_cap(input int r);
      if (r >= NUM_CFG || r >= NUM_RES) return 0;
      return (cap_setting[r] > MAX_CAP) ? MAX_CAP : int'(cap_setting[r]);
   endfunction

   task automatic place_activity(input int r, input int q, input int cap,
                                 input longint start, input longint stop);
      int     row;
      int     base;
      longint prev;
      longint nst;
      longint area;
      longint lo;
      longint diff;
      longint cur;
      int     c;
      row  = r * MAX_CAP;
      base = cap - q;
      prev = (q < cap) ? longint'(free_time[row + base - 1]) : stop;
      nst  = (stop < prev) ? stop : prev;
      area = q * (stop - start);
      if (start < prev) begin
         for (int k = base; k < cap; k++) free_time[row + k] = nst[TIME_BITS-1:0];
         area -= q * (nst - start);
      end
      c   = 0;
      nst = stop;
      for (int k = 0; area > 0 && k < cap; k++) begin
         cur = free_time[row + k];
         if (cur < nst) begin
            lo = (cur > start) ? cur : start;
            if (c >= q && c - q < MAX_CAP) nst = swap_time[c - q];
            diff = nst - lo;
            if (area - diff > 0) begin
               area -= diff;
               if (c < MAX_CAP) swap_time[c] = cur;
               c++;
               free_time[row + k] = TIME_BITS'(nst & TIME_MASK);
            end else begin
               free_time[row + k] = TIME_BITS'((nst - diff + area) & TIME_MASK);
               break;
            end
         end
      end
   endtask

   task automatic step_request(input logic mode_bit, input logic [39:0] d,
                               input logic last);
      mode_type m;
      int       r;
      int       q;
      int       cap;
      longint   start;
      longint   stop;
      logic [TIME_BITS-1:0] v;
      m     = mode_type'(mode_bit);
      r     = int'(d[1:0]);
      q     = int'(d[6:2]);
      start = longint'(d[22:7]);
      stop  = longint'(d[38:23]);
      cap   = usable_cap(r);
      if (m == MODE_ADD) begin
         if (q != 0 && q <= cap && stop > start) place_activity(r, q, cap, start, stop);
      end else begin
         if (q != 0 && q <= cap) begin
            v = free_time[r * MAX_CAP + cap - q];
            if (v > running_max) running_max = v;
         end
         if (last) begin
            expected_starts.insert(expected_starts.size(), running_max);
            running_max = '0;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (cap_setting[i]) cap_setting[i] = 5'd16;
         foreach (free_time[i]) free_time[i] = '0;
         running_max = '0;
         expected_starts.delete();
         pending_starts = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_starts.size() == 0)
               report($sformatf("unexpected earliest start %0d", rsp_tdata));
            else if (rsp_tdata !== expected_starts[0])
               report($sformatf("earliest start %0d, want %0d", rsp_tdata,
                                expected_starts[0]));
            if (expected_starts.size() != 0) void'(expected_starts.pop_front());
         end
         if (csr_valid && csr_ready && csr_index < NUM_CFG)
            cap_setting[csr_index[1:0]] = csr_data;
         if (req_tvalid && req_tready) step_request(req_tuser, req_tdata, req_tlast);
         pending_starts = expected_starts.size();
      end
   end
endmodule
`default_nettype wire

/* tb/resource_unit_profile_scheduler_tb.sv */
// Testbench top: clock, reset, request and capacity stimulus, and the verdict.
`default_nettype none
module resource_unit_profile_scheduler_tb
   import rups_pkg::*;
();
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [39:0]          req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CAP_W-1:0]     csr_data = '0;
   int                   fail_count;
   int                   pending_starts;
   int                   hold_cycles = 0;
   bit                   steady = 1'b0;
   int                   query_left = 0;

   always #2 clock = ~clock;

   resource_unit_profile_scheduler dut (.*);
   resource_unit_profile_checker chk (.*);

   initial begin
      #(4 * 3_000_000);
      $display("Test completed with failures");
      $finish;
   end

   // receiver side: random stalls, always ready while steady is set, plus a long hold-off on request
   initial begin
      int stall_left;
      int pick;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            pick = $urandom_range(99);
            if (pick < 70) rsp_tready <= 1'b1;
            else begin
               rsp_tready <= 1'b0;
               stall_left = (pick < 95) ? $urandom_range(2) : $urandom_range(40, 10);
            end
         end
      end
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (steady || p < 60) return 0;
      if (p < 95) return $urandom_range(3, 1);
      return $urandom_range(60, 15);
   endfunction

   task automatic send_request(input mode_type m, input int r, input int q,
                               input int st, input int sp, input bit last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, sp[15:0], st[15:0], q[4:0], r[1:0]};
      req_tuser  <= m;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_starts != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_cap(input int idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx[CSR_IDX_W-1:0];
      csr_data  <= value[CAP_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic int rand_time();
      return ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(300);
   endfunction

   task automatic random_request();
      int st;
      int sp;
      int q;
      int p;
      p  = $urandom_range(99);
      q  = (p < 90) ? $urandom_range(16, 1) : $urandom_range(31);
      st = rand_time();
      sp = (p < 85) ? st + $urandom_range(120, 1) : rand_time();
      if (sp > 65535) sp = 65535;
      if (query_left == 0 && $urandom_range(1)) begin
         send_request(MODE_ADD, $urandom_range(3), q, st, sp, 1'($urandom_range(1)));
      end else begin
         if (query_left == 0) query_left = $urandom_range(4, 1);
         query_left--;
         send_request(MODE_QUERY, $urandom_range(3), q, st, sp, query_left == 0);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes and ignored cases
      send_request(MODE_QUERY, 0, 16, 0, 0, 1);
      send_request(MODE_QUERY, 1, 0, 0, 0, 1);
      send_request(MODE_ADD, 0, 4, 10, 50, 0);
      send_request(MODE_ADD, 0, 16, 0, 65535, 1);
      send_request(MODE_ADD, 1, 0, 5, 20, 0);
      send_request(MODE_ADD, 1, 17, 5, 20, 0);
      send_request(MODE_ADD, 1, 31, 5, 20, 0);
      send_request(MODE_ADD, 2, 3, 40, 40, 0);
      send_request(MODE_ADD, 2, 3, 65535, 0, 0);
      send_request(MODE_ADD, 2, 1, 0, 1, 0);
      send_request(MODE_ADD, 3, 8, 100, 65535, 0);
      send_request(MODE_ADD, 3, 8, 65534, 65535, 0);
      send_request(MODE_QUERY, 0, 1, 65535, 65535, 0);
      send_request(MODE_QUERY, 2, 31, 0, 0, 0);
      send_request(MODE_QUERY, 3, 16, 0, 0, 1);
      send_request(MODE_QUERY, 3, 1, 0, 0, 1);
      send_request(MODE_QUERY, 2, 1, 0, 0, 1);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               write_cap(0, 1); write_cap(1, 16); write_cap(2, 7); write_cap(3, 3);
            end
            1: begin
               write_cap(0, 0); write_cap(1, 31); write_cap(2, 16);
               write_cap(3, 1); write_cap(5, 2); write_cap(7, 9);
            end
            2: begin
               for (int i = 0; i < NUM_CFG; i++) write_cap(i, $urandom_range(16, 1));
            end
            default: begin
               for (int i = 0; i < NUM_CFG; i++) write_cap(i, 16);
            end
         endcase
         query_left = 0;
         for (int n = 0; n < 270; n++) begin
            if (n == 100 && ph == 1) begin
               hold_cycles = 400;
               for (int j = 0; j < 20; j++) send_request(MODE_QUERY, j % 4, 1, 0, 0, 1);
            end
            if (n == 150) steady = 1'b1;
            if (n == 190) steady = 1'b0;
            random_request();
         end
         if (query_left != 0) send_request(MODE_QUERY, 0, 1, 0, 0, 1);
         drain();
      end

      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
